/* src/timestamp_lru_victim_select_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp LRU victim selector
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_LRU_VICTIM_SELECT_ASSERT_SVH
`define TIMESTAMP_LRU_VICTIM_SELECT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLVS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlvs: implication check failed");
// next-cycle implication
`define TLVS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlvs: next-cycle check failed");
`else
`define TLVS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TLVS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/tlvs_pkg.sv */
// ----------------------------------------------------------------------------
// tlvs_pkg
// Shared types, opcodes and defaults of the timestamp LRU victim selector.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvs_pkg;

    localparam int WAYS_DEF      = 8;
    localparam int SETS_DEF      = 256;
    localparam int TIME_BITS_DEF = 32;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] OP_TOUCH      = 3'd0;
    localparam logic [2:0] OP_FILL_RESET = 3'd1;
    localparam logic [2:0] OP_INVALIDATE = 3'd2;
    localparam logic [2:0] OP_VICTIM_Q   = 3'd3;
    localparam logic [2:0] OP_DEAD_Q     = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  set_index;
        logic [2:0]  way_index;
        logic [31:0] current_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0] chosen_way;
        logic       chosen_valid;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_QUERY_LRU,
        CMD_QUERY_DEAD,
        CMD_NULL_RESULT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  set_index;
        logic [2:0]  way_index;
        logic [31:0] wr_time;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_flags;

endpackage : tlvs_pkg

`default_nettype wire

/* src/timestamp_lru_victim_select.sv */
// ----------------------------------------------------------------------------
// timestamp_lru_victim_select: per-way last-touch timestamps, LRU/dead victim
// Update: written to the store as the back pops it from the queue; query: row
// read, one way compared per cycle, result load; no other pops meanwhile.
// Reset: clearing pass over all SETS store rows, no items taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timestamp_lru_victim_select_assert.svh"

module timestamp_lru_victim_select
    import tlvs_pkg::*;
#(
    parameter int WAYS      = WAYS_DEF,
    parameter int SETS      = SETS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // configuration: dead-block query enable
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    // input items
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    // result items
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_item     o_item
);

    // Dead-block enable, set at reset, read by the back only when a dead-block
    // scan ends. The user writes it only while idle; the block does not check.
    logic r_dead_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_dead_en <= i_cfg_wdata;
        end
    end

    // Front to queue
    logic     push;
    t_cmd     push_cmd;
    // Queue to back
    logic     pop;
    t_cmd     head_cmd;
    t_q_flags q_flags;
    // Back status
    logic     clearing;

    // Front: decodes opcode, drops out-of-range updates and undefined
    // opcodes, marks out-of-range queries as null results. Stalls while
    // the queue is full or the store is still being cleared.
    tlvs_front #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_front (
        .i_valid    (i_valid),
        .i_item     (i_item),
        .i_q_flags  (q_flags),
        .i_clearing (clearing),
        .o_ready    (o_ready),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Short command queue: lets the front keep taking updates while the
    // back scans a set or waits on a stalled output.
    tlvs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_flags (q_flags)
    );

    // Back: owns the timestamp store. Writes go straight to the addressed
    // way; queries read the set's row, then walk the ways one per cycle
    // keeping the running minimum and the minimum it displaced last.
    tlvs_back #(
        .WAYS      (WAYS),
        .SETS      (SETS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dead_en  (r_dead_en),
        .i_cmd      (head_cmd),
        .i_q_flags  (q_flags),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_item     (o_item),
        .i_ready    (i_ready)
    );

    // Assertions
    `TLVS_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, o_ready, !clearing)
    `TLVS_ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, push, !q_flags.full)
    `TLVS_ASSERT_IMP(a_invalid_way_zero, i_clk, i_rst_n, o_valid && !o_item.chosen_valid, o_item.chosen_way == 3'd0)
    `TLVS_ASSERT_NXT(a_push_fills_queue, i_clk, i_rst_n, push, !q_flags.empty)

endmodule : timestamp_lru_victim_select

`default_nettype wire

/* src/tlvs_front.sv */
// ----------------------------------------------------------------------------
// tlvs_front
// Accepts input items, range-checks them and turns them into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvs_front
    import tlvs_pkg::*;
#(
    parameter int WAYS = WAYS_DEF,
    parameter int SETS = SETS_DEF
) (
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    input  wire t_q_flags i_q_flags,
    input  wire logic     i_clearing,
    output logic          o_ready,
    output logic          o_push,
    output t_cmd          o_cmd
);

    logic set_ok;
    logic way_ok;
    logic keep;

    assign set_ok  = 32'(i_item.set_index) < 32'(SETS);
    assign way_ok  = 32'(i_item.way_index) < 32'(WAYS);
    assign o_ready = !i_q_flags.full && !i_clearing;

    always_comb begin
        o_cmd.set_index = i_item.set_index;
        o_cmd.way_index = i_item.way_index;
        o_cmd.wr_time   = i_item.current_time;
        o_cmd.kind      = CMD_NULL_RESULT;
        keep            = 1'b0;
        unique case (i_item.opcode) inside
            OP_TOUCH, OP_FILL_RESET: begin
                o_cmd.kind = CMD_WRITE;
                keep       = set_ok && way_ok;
            end
            OP_INVALIDATE: begin
                o_cmd.kind    = CMD_WRITE;
                o_cmd.wr_time = '0;
                keep          = set_ok && way_ok;
            end
            OP_VICTIM_Q: begin
                o_cmd.kind = set_ok ? CMD_QUERY_LRU : CMD_NULL_RESULT;
                keep       = 1'b1;
            end
            OP_DEAD_Q: begin
                o_cmd.kind = set_ok ? CMD_QUERY_DEAD : CMD_NULL_RESULT;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;  // undefined opcodes are swallowed
            end
        endcase
    end

    assign o_push = i_valid && o_ready && keep;

endmodule : tlvs_front

`default_nettype wire

/* src/tlvs_fifo.sv */
// ----------------------------------------------------------------------------
// tlvs_fifo
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvs_fifo
    import tlvs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output t_q_flags  o_flags
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd         = r_slot[r_rd_ptr];
    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count == CW'(QUEUE_DEPTH));

endmodule : tlvs_fifo

`default_nettype wire

/* src/tlvs_back.sv */
// ----------------------------------------------------------------------------
// tlvs_back
// Timestamp store, clearing pass, serial way scan and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvs_back
    import tlvs_pkg::*;
#(
    parameter int WAYS      = WAYS_DEF,
    parameter int SETS      = SETS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_dead_en,
    input  wire t_cmd     i_cmd,
    input  wire t_q_flags i_q_flags,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_valid,
    output t_out_item     o_item,
    input  wire logic     i_ready
);

    localparam int AW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WB  = $clog2(WAYS);
    localparam int SIW = (AW > 8) ? AW : 8;
    localparam int WIW = (WB > 3) ? WB : 3;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_RESULT = 4'b1000
    } t_back_state;

    t_back_state          r_state, n_state;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic [WB-1:0]        r_scan_idx, n_scan_idx;
    logic [WB-1:0]        r_best, n_best;
    logic [WB-1:0]        r_prev, n_prev;
    logic [TIME_BITS-1:0] r_best_t, n_best_t;
    logic                 r_is_dead, n_is_dead;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_item, n_out_item;

    logic [TIME_BITS-1:0] r_mem [SETS][WAYS];
    logic [TIME_BITS-1:0] r_row [WAYS];

    logic [SIW-1:0]       set_wide;
    logic [WIW-1:0]       way_wide;
    logic [AW-1:0]        cmd_addr;
    logic [WB-1:0]        cmd_way;
    logic [TIME_BITS-1:0] cmd_time;
    logic [TIME_BITS-1:0] cur_t;
    logic [WIW-1:0]       best_wide;
    logic [WIW-1:0]       prev_wide;
    logic                 out_free;
    logic                 clr_we;
    logic                 upd_we;
    logic                 rd_en;
    logic                 scan_last;
    logic                 dead_ok;

    assign set_wide  = SIW'(i_cmd.set_index);
    assign way_wide  = WIW'(i_cmd.way_index);
    assign cmd_addr  = set_wide[AW-1:0];
    assign cmd_way   = way_wide[WB-1:0];
    assign cmd_time  = TIME_BITS'(i_cmd.wr_time);
    assign cur_t     = r_row[r_scan_idx];
    assign best_wide = WIW'(r_best);
    assign prev_wide = WIW'(r_prev);
    assign scan_last = (r_scan_idx == WB'(WAYS - 1));
    assign out_free  = !r_out_valid || i_ready;
    assign dead_ok   = i_dead_en && (r_best != '0);

    assign clr_we = (r_state == ST_CLEAR);
    assign o_pop  = (r_state == ST_IDLE) && !i_q_flags.empty
                    && ((i_cmd.kind != CMD_NULL_RESULT) || out_free);
    assign upd_we = o_pop && (i_cmd.kind == CMD_WRITE);
    assign rd_en  = o_pop && ((i_cmd.kind == CMD_QUERY_LRU) || (i_cmd.kind == CMD_QUERY_DEAD));

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_scan_idx  = r_scan_idx;
        n_best      = r_best;
        n_prev      = r_prev;
        n_best_t    = r_best_t;
        n_is_dead   = r_is_dead;
        n_out_valid = r_out_valid && !i_ready;
        n_out_item  = r_out_item;

        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_pop) begin
                    case (i_cmd.kind) inside
                        CMD_QUERY_LRU, CMD_QUERY_DEAD: begin
                            n_state    = ST_SCAN;
                            n_scan_idx = '0;
                            n_is_dead  = (i_cmd.kind == CMD_QUERY_DEAD);
                        end
                        CMD_NULL_RESULT: begin
                            n_out_valid             = 1'b1;
                            n_out_item.chosen_way   = '0;
                            n_out_item.chosen_valid = 1'b0;
                        end
                        default: begin
                            n_state = ST_IDLE;  // write done in the store
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_scan_idx = r_scan_idx + 1'b1;
                if (r_scan_idx == '0) begin
                    n_best   = '0;
                    n_prev   = '0;
                    n_best_t = r_row[0];
                end else if (cur_t < r_best_t) begin
                    n_prev   = r_best;
                    n_best   = r_scan_idx;
                    n_best_t = cur_t;
                end
                if (scan_last) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if (!r_is_dead) begin
                        n_out_item.chosen_way   = best_wide[2:0];
                        n_out_item.chosen_valid = 1'b1;
                    end else begin
                        n_out_item.chosen_way   = dead_ok ? prev_wide[2:0] : 3'd0;
                        n_out_item.chosen_valid = dead_ok;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_scan_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_scan_idx  <= n_scan_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_prev     <= n_prev;
        r_best_t   <= n_best_t;
        r_is_dead  <= n_is_dead;
        r_out_item <= n_out_item;
    end

    // timestamp store: row-wide read, per-way write
    always_ff @(posedge i_clk) begin
        if (clr_we) begin
            for (int w = 0; w < WAYS; w++) begin
                r_mem[r_clr_addr][w] <= '0;
            end
        end else if (upd_we) begin
            r_mem[cmd_addr][cmd_way] <= cmd_time;
        end
        if (rd_en) begin
            r_row <= r_mem[cmd_addr];
        end
    end

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_item     = r_out_item;

endmodule : tlvs_back

`default_nettype wire
